@@ hw/rtl/bqc_pkg.sv @@
// Package for the cascaded biquad IIR filter core: widths, register
// indexes, coefficient reset values, sequencer tag and coefficient types.
// No dependencies.
`default_nettype none

package bqc_pkg;

  // Fixed widths
  localparam int COEF_W       = 32;  // Q2.30 coefficient registers
  localparam int DELAY_W      = 40;  // delay-line word
  localparam int MAX_SECTIONS = 2;
  localparam int SEC_W        = 1;   // section index width
  localparam int NUM_REGS     = 6;
  localparam int REG_IDX_W    = 3;

  // Shared multiplier: coef x 24-bit slice of a delay word
  localparam int LO_BITS = 16;                 // low slice, unsigned
  localparam int MUL_B_W = DELAY_W - LO_BITS;  // high slice, signed
  localparam int MUL_W   = COEF_W + MUL_B_W;
  localparam int PROD_W  = COEF_W + DELAY_W;   // full exact product

  // Parameter defaults
  localparam int DEF_SECTIONS       = 2;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 30;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SEC0_MID  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SEC0_DEN1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SEC0_DEN2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEC1_MID  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SEC1_DEN1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SEC1_DEN2 = 3'd5;

  // Coefficient reset values
  localparam logic signed [COEF_W-1:0] RST_SEC0_MID  = -32'sd2147474076;
  localparam logic signed [COEF_W-1:0] RST_SEC0_DEN1 = -32'sd2063596172;
  localparam logic signed [COEF_W-1:0] RST_SEC0_DEN2 = 32'sd993708443;
  localparam logic signed [COEF_W-1:0] RST_SEC1_MID  = -32'sd2147428970;
  localparam logic signed [COEF_W-1:0] RST_SEC1_DEN1 = -32'sd2136708570;
  localparam logic signed [COEF_W-1:0] RST_SEC1_DEN2 = 32'sd1064125342;

  // Product kinds within one section
  localparam logic [1:0] KIND_A1 = 2'd0;  // a1 * w1
  localparam logic [1:0] KIND_A2 = 2'd1;  // a2 * w2
  localparam logic [1:0] KIND_B1 = 2'd2;  // b1 * w1

  typedef struct packed {
    logic             vld;
    logic             hi;    // high slice of the delay word
    logic [1:0]       kind;
    logic [SEC_W-1:0] sec;
  } bqc_tag_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] mid;
    logic signed [COEF_W-1:0] den1;
    logic signed [COEF_W-1:0] den2;
  } bqc_coef_t;

endpackage

`default_nettype wire

@@ hw/rtl/bqc_coef_regs.sv @@
// Coefficient register file: six Q2.30 registers behind a plain write port.
// Depends on bqc_pkg.
`default_nettype none

module bqc_coef_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bqc_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  wire logic [bqc_pkg::COEF_W-1:0]     cfg_data,
  output bqc_pkg::bqc_coef_t                  coef_o [bqc_pkg::MAX_SECTIONS]
);
  import bqc_pkg::*;

  bqc_coef_t coef_r [MAX_SECTIONS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0].mid  <= RST_SEC0_MID;
      coef_r[0].den1 <= RST_SEC0_DEN1;
      coef_r[0].den2 <= RST_SEC0_DEN2;
      coef_r[1].mid  <= RST_SEC1_MID;
      coef_r[1].den1 <= RST_SEC1_DEN1;
      coef_r[1].den2 <= RST_SEC1_DEN2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEC0_MID:  coef_r[0].mid  <= cfg_data;
        REG_SEC0_DEN1: coef_r[0].den1 <= cfg_data;
        REG_SEC0_DEN2: coef_r[0].den2 <= cfg_data;
        REG_SEC1_MID:  coef_r[1].mid  <= cfg_data;
        REG_SEC1_DEN1: coef_r[1].den1 <= cfg_data;
        REG_SEC1_DEN2: coef_r[1].den2 <= cfg_data;
        default: ;  // out-of-range index: ignored
      endcase
    end
  end

  assign coef_o = coef_r;

endmodule

`default_nettype wire

@@ hw/rtl/bqc_mul_round.sv @@
// Shared multiply-and-round unit: one 32x24 partial product per cycle,
// two partials per coefficient product, round half up. Depends on bqc_pkg.
`default_nettype none

module bqc_mul_round #(
  parameter int COEF_FRAC_BITS = bqc_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire bqc_pkg::bqc_tag_t                             tag_i,
  input  wire logic signed [bqc_pkg::COEF_W-1:0]             coef_i,
  input  wire logic signed [bqc_pkg::DELAY_W-1:0]            w_i,
  output logic signed [bqc_pkg::PROD_W-COEF_FRAC_BITS-1:0]   rnd_o,
  output bqc_pkg::bqc_tag_t                                  tag_o
);
  import bqc_pkg::*;

  localparam int RND_W = PROD_W - COEF_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [MUL_B_W-1:0] b_op;
  logic signed [MUL_W-1:0]   mul_r;
  bqc_tag_t                  tag1_r;
  bqc_tag_t                  tag2_r;
  logic signed [PROD_W-1:0]  plo_r;
  logic signed [PROD_W-1:0]  full;
  logic signed [RND_W-1:0]   rnd_r;

  // low slice is zero-extended, high slice carries the sign
  assign b_op = tag_i.hi ? w_i[DELAY_W-1:LO_BITS]
                         : MUL_B_W'($unsigned(w_i[LO_BITS-1:0]));

  assign full = plo_r + (PROD_W'(mul_r) <<< LO_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_i;
      // rounded result is valid only after the high partial
      tag2_r <= {tag1_r.vld & tag1_r.hi, tag1_r.hi, tag1_r.kind, tag1_r.sec};
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= coef_i * b_op;
    if (tag1_r.vld && !tag1_r.hi) begin
      plo_r <= PROD_W'(mul_r) + HALF;
    end
    if (tag1_r.vld && tag1_r.hi) begin
      rnd_r <= full[PROD_W-1:COEF_FRAC_BITS];
    end
  end

  assign rnd_o = rnd_r;
  assign tag_o = tag2_r;

endmodule

`default_nettype wire

@@ hw/rtl/biquad_cascade_iir_filter_core.sv @@
// Top level of the cascaded direct-form-II biquad IIR filter core.
// Holds the sequencer, accumulator, delay line and output register.
// Depends on bqc_pkg, bqc_coef_regs and bqc_mul_round.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in_     | slave     | in_tvalid / in_tready | in_tdata: sample_in; in_tlast
//  out_    | master    | out_tvalid/out_tready | out_tdata: sample_out; out_tlast
//  cfg_    | write     | cfg_we                | cfg_addr, cfg_data
//
// Each section issues three products on the one shared multiplier, two 32x24
// partials each; a new item is accepted only after the previous result has
// been loaded into the output register.
// The two-stage multiply/round pipeline overlaps issue with accumulation.
// Reset is synchronous, active low: delay line zeroed, coefficients to defaults.
// A result waits in the output register; a stalled output holds the last
// transaction until it is taken, and the next item is accepted meanwhile.
`default_nettype none

module biquad_cascade_iir_filter_core #(
  parameter int SECTIONS       = bqc_pkg::DEF_SECTIONS,
  parameter int SAMPLE_BITS    = bqc_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = bqc_pkg::DEF_COEF_FRAC_BITS,
  localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [DATA_W-1:0]             in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  wire logic                          in_tlast,   // block_end_in
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [DATA_W-1:0]                  out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic                               out_tlast,  // block_end_out
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [bqc_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [bqc_pkg::COEF_W-1:0]    cfg_data
);
  import bqc_pkg::*;

  localparam int RND_W = PROD_W - COEF_FRAC_BITS;
  localparam int SUM_W = RND_W + 2;
  localparam logic [2:0] LAST_SLOT = 3'd5;
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // saturate an accumulator sum to the delay word
  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    r = '0;
    if (&v[SUM_W-1:DELAY_W-1] || ~|v[SUM_W-1:DELAY_W-1]) begin
      r = v[DELAY_W-1:0];
    end else begin
      r[DELAY_W-1] = 1'b1;
      if (!v[SUM_W-1]) r = ~r;
    end
    return r;
  endfunction

  // saturate a delay word to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [DELAY_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    r = '0;
    if (&v[DELAY_W-1:SAMPLE_BITS-1] || ~|v[DELAY_W-1:SAMPLE_BITS-1]) begin
      r = v[SAMPLE_BITS-1:0];
    end else begin
      r[SAMPLE_BITS-1] = 1'b1;
      if (!v[DELAY_W-1]) r = ~r;
    end
    return r;
  endfunction

  // control
  logic [1:0]       state_r;
  logic             issuing_r;
  logic [SEC_W-1:0] sec_r;
  logic [2:0]       slot_r;
  logic             out_valid_r;

  // datapath
  logic signed [DELAY_W-1:0]     x_r;     // section input, then final y
  logic signed [SUM_W-1:0]       acc_r;
  logic signed [DELAY_W-1:0]     w0_r;
  logic signed [DELAY_W-1:0]     delay_one_r [MAX_SECTIONS];
  logic signed [DELAY_W-1:0]     delay_two_r [MAX_SECTIONS];
  logic                          last_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;

  bqc_coef_t                coef [MAX_SECTIONS];
  bqc_tag_t                 iss_tag;
  logic signed [COEF_W-1:0] iss_coef;
  logic signed [DELAY_W-1:0] iss_w;
  logic signed [RND_W-1:0]  rnd;
  bqc_tag_t                 rnd_tag;
  logic signed [SUM_W-1:0]  y_sum;
  logic                     in_acc;
  logic                     out_load;

  bqc_coef_regs u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .coef_o   (coef)
  );

  // issue: slot[2:1] picks the product, slot[0] the delay-word slice
  always_comb begin
    iss_tag.vld  = issuing_r;
    iss_tag.hi   = slot_r[0];
    iss_tag.kind = slot_r[2:1];
    iss_tag.sec  = sec_r;
    iss_w        = delay_one_r[sec_r];
    unique case (slot_r[2:1])
      KIND_A1: iss_coef = coef[sec_r].den1;
      KIND_A2: begin
        iss_coef = coef[sec_r].den2;
        iss_w    = delay_two_r[sec_r];
      end
      default: iss_coef = coef[sec_r].mid;
    endcase
  end

  bqc_mul_round #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (iss_tag),
    .coef_i (iss_coef),
    .w_i    (iss_w),
    .rnd_o  (rnd),
    .tag_o  (rnd_tag)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign y_sum     = SUM_W'(w0_r) + SUM_W'(rnd) + SUM_W'(delay_two_r[rnd_tag.sec]);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issuing_r   <= 1'b0;
      sec_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tvalid && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r   <= ST_RUN;
            issuing_r <= 1'b1;
            sec_r     <= '0;
            slot_r    <= '0;
          end
        end
        ST_RUN: begin
          if (issuing_r) begin
            if (slot_r == LAST_SLOT) begin
              slot_r <= '0;
              if (sec_r == LAST_SEC) issuing_r <= 1'b0;
              else sec_r <= sec_r + 1'b1;
            end else begin
              slot_r <= slot_r + 3'd1;
            end
          end
          if (rnd_tag.vld && rnd_tag.kind == KIND_B1 && rnd_tag.sec == LAST_SEC) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // delay line: cleared by reset, shifted when a section's output is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_SECTIONS; k++) begin
        delay_one_r[k] <= '0;
        delay_two_r[k] <= '0;
      end
    end else if (rnd_tag.vld && rnd_tag.kind == KIND_B1) begin
      delay_two_r[rnd_tag.sec] <= delay_one_r[rnd_tag.sec];
      delay_one_r[rnd_tag.sec] <= w0_r;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= DELAY_W'(signed'(in_tdata[SAMPLE_BITS-1:0]));
      last_r <= in_tlast;
    end
    if (rnd_tag.vld) begin
      unique case (rnd_tag.kind)
        KIND_A1: acc_r <= SUM_W'(x_r) - SUM_W'(rnd);
        KIND_A2: w0_r  <= sat_delay(acc_r - SUM_W'(rnd));
        default: x_r   <= sat_delay(y_sum);  // y feeds the next section
      endcase
    end
    if (out_load) begin
      out_sample_r <= sat_sample(x_r);
      out_last_r   <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'($unsigned(out_sample_r));
  assign out_tlast  = out_last_r;

  // no product may be in flight while a new transaction can be taken
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !rnd_tag.vld && !issuing_r)
    else $error("multiplier pipeline busy while idle");

  // accepting a sample always starts issue of the first product
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> issuing_r && sec_r == '0 && slot_r == '0)
    else $error("accepted sample did not start the sequencer");

  // the output register is loaded only after the last section finished
  a_done_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DONE) |-> $past(rnd_tag.vld) && $past(rnd_tag.kind) == KIND_B1)
    else $error("result completed without a last-section output");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for biquad_cascade_iir_filter_core: directed table, then random
// phases over coefficient sets and handshake pressure, checked against a bit-true predictor.
// Depends on bqc_pkg and the core RTL only.

module tb;
  import bqc_pkg::*;

  localparam int SB       = DEF_SAMPLE_BITS;
  localparam int CFRAC    = DEF_COEF_FRAC_BITS;
  localparam int DATA_W   = ((SB + 7) / 8) * 8;
  localparam int LAT      = 6 * DEF_SECTIONS + 4;   // accept-to-accept cycles
  localparam int WDOG_MAX = 5000;                   // cycles with no transaction
  localparam int ITEMS_PER_PH = 250;
  localparam int NUM_PH   = 6;

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  // register indexes past the last coefficient; writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_OOR_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OOR_B = 3'd7;

  // power-on coefficients in register-index order
  localparam logic [COEF_W-1:0] RST_COEF [NUM_REGS] = '{
    RST_SEC0_MID, RST_SEC0_DEN1, RST_SEC0_DEN2,
    RST_SEC1_MID, RST_SEC1_DEN1, RST_SEC1_DEN2
  };

  typedef enum logic [2:0] {
    CSET_KEEP, CSET_RESET, CSET_MAX, CSET_MIN, CSET_ZERO, CSET_RAND
  } coef_set_t;

  typedef struct packed {
    coef_set_t  cs;
    logic [6:0] idle_pct;    // sender gap chance per cycle
    logic [6:0] stall_pct;   // receiver stall chance per cycle
  } ph_cfg_t;

  // coefficient set and handshake pressure per random phase
  localparam ph_cfg_t PH_TAB [NUM_PH] = '{
    '{CSET_KEEP,  7'd0,  7'd0},
    '{CSET_RAND,  7'd86, 7'd0},
    '{CSET_MAX,   7'd0,  7'd86},
    '{CSET_MIN,   7'd10, 7'd10},
    '{CSET_ZERO,  7'd0,  7'd86},
    '{CSET_RESET, 7'd86, 7'd0}
  };

  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] addr;
    logic [COEF_W-1:0]    value;      // register data, or sample in the low bits
    logic                 blk_end;
    logic                 has_fixed;  // expected sample typed in below
    logic [SB-1:0]        fixed;
  } dir_row_t;

  // Directed part. Only the first row has a hand-typed answer: with the delay
  // line cleared by reset, both sections pass the sample straight through.
  localparam int NDIR = 22;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{1'b0, '0,        32'h007FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
    '{1'b0, '0,        32'h00800000, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00000000, 1'b1, 1'b0, '0},
    '{1'b0, '0,        32'h00000001, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00FFFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h007FFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h007FFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h007FFFFF, 1'b1, 1'b0, '0},
    '{1'b0, '0,        32'h00800000, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00800000, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00800000, 1'b1, 1'b0, '0},
    '{1'b1, REG_OOR_A, 32'hFFFFFFFF, 1'b0, 1'b0, '0},
    '{1'b1, REG_OOR_B, 32'h80000000, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00000000, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00000000, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00555555, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00AAAAAA, 1'b1, 1'b0, '0},
    '{1'b0, '0,        32'h00123456, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00EDCBA9, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00000001, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00FFFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0,        32'h00000000, 1'b1, 1'b0, '0}
  };

  typedef struct packed {
    logic [SB-1:0] sample;
    logic          blk_end;
  } filt_result_t;

  // DUT signals; those the bench drives are known from time zero
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata = '0;    // [SB-1:0] sample_in
  logic                 in_tlast = 1'b0;  // block_end_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;        // [SB-1:0] sample_out
  logic                 out_tlast;        // block_end_out
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  // predictor state: coefficients and per-section delay line
  bqc_coef_t                coef_q [MAX_SECTIONS];
  logic signed [DELAY_W-1:0] w1_q [MAX_SECTIONS];
  logic signed [DELAY_W-1:0] w2_q [MAX_SECTIONS];

  filt_result_t pending_q [$];   // expected results, oldest first
  filt_result_t want_r;
  int           err_cnt = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  function automatic logic signed [63:0] clip(logic signed [63:0] v, int bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // exact coef*delay product, round half up at the coefficient's binary point
  function automatic logic signed [63:0] coef_mul(logic signed [COEF_W-1:0] c,
                                                  logic signed [DELAY_W-1:0] w);
    logic signed [PROD_W+7:0] p;
    p = c * w;
    p = p + ((PROD_W+8)'(1) <<< (CFRAC - 1));
    return 64'(p >>> CFRAC);
  endfunction

  // out-of-range indexes fall through and leave the coefficients alone
  function automatic void coef_write(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
    case (idx)
      REG_SEC0_MID:  coef_q[0].mid  = v;
      REG_SEC0_DEN1: coef_q[0].den1 = v;
      REG_SEC0_DEN2: coef_q[0].den2 = v;
      REG_SEC1_MID:  coef_q[1].mid  = v;
      REG_SEC1_DEN1: coef_q[1].den1 = v;
      REG_SEC1_DEN2: coef_q[1].den2 = v;
      default: ;
    endcase
  endfunction

  // one sample through the cascade; advances the delay lines
  function automatic logic [SB-1:0] filter_step(logic signed [SB-1:0] x_in);
    logic signed [63:0] x;
    logic signed [63:0] w0;
    logic signed [63:0] y;
    int k;
    x = x_in;
    for (k = 0; k < DEF_SECTIONS; k++) begin
      w0 = clip(x - coef_mul(coef_q[k].den1, w1_q[k])
                  - coef_mul(coef_q[k].den2, w2_q[k]), DELAY_W);
      y  = clip(w0 + coef_mul(coef_q[k].mid, w1_q[k]) + w2_q[k], DELAY_W);
      w2_q[k] = w1_q[k];
      w1_q[k] = w0[DELAY_W-1:0];
      x = y;
    end
    y = clip(x, SB);
    return y[SB-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  // Offer one sample; the expectation is queued at the accepting edge.
  // tvalid stays high into the next call unless a gap is drawn.
  task automatic push_sample(logic [SB-1:0] s, logic e, logic has_fixed,
                             logic [SB-1:0] fixed_val);
    logic [SB-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(s);
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = filter_step(s);
    pending_q.push_back('{sample: has_fixed ? fixed_val : pred, blk_end: e});
  endtask

  // Park the sender until every result is back and the core takes input again.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_tvalid || !in_tready) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Raises cfg_we for one edge; the caller drops it after the last write.
  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    coef_write(idx, v);
  endtask

  biquad_cascade_iir_filter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: random backpressure, and every result transaction is checked
  // against the oldest expectation. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction pending",
                                  out_tdata[SB-1:0]));
      end else begin
        want_r = pending_q.pop_front();
        if (out_tdata[SB-1:0] !== want_r.sample)
          report_mismatch($sformatf("sample_out got %h want %h",
                                    out_tdata[SB-1:0], want_r.sample));
        if (out_tlast !== want_r.blk_end)
          report_mismatch($sformatf("block_end_out got %b want %b",
                                    out_tlast, want_r.blk_end));
      end
    end
  end

  // Watchdog: too long without any transaction on either stream.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WDOG_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [SB-1:0]     s;
    logic [31:0]       r;
    logic [COEF_W-1:0] v;
    int i;
    int n;
    int p;

    // predictor starts from the power-on state
    for (i = 0; i < NUM_REGS; i++) coef_write(REG_IDX_W'(i), RST_COEF[i]);
    for (i = 0; i < MAX_SECTIONS; i++) begin
      w1_q[i] = '0;
      w2_q[i] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sample extremes, block-end marks, dropped out-of-range writes.
    for (i = 0; i < NDIR; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        wait_idle();
        cfg_write(DIR_TAB[i].addr, DIR_TAB[i].value);
        if (i == NDIR - 1 || !DIR_TAB[i+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        push_sample(DIR_TAB[i].value[SB-1:0], DIR_TAB[i].blk_end,
                    DIR_TAB[i].has_fixed, DIR_TAB[i].fixed);
      end
    end

    // Random phases. Coefficients change only with the pipe drained.
    for (p = 0; p < NUM_PH; p++) begin
      wait_idle();
      send_idle_pct  = PH_TAB[p].idle_pct;
      recv_stall_pct = PH_TAB[p].stall_pct;
      if (PH_TAB[p].cs != CSET_KEEP) begin
        for (i = 0; i < NUM_REGS; i++) begin
          case (PH_TAB[p].cs)
            CSET_MAX:  v = {1'b0, {(COEF_W-1){1'b1}}};
            CSET_MIN:  v = {1'b1, {(COEF_W-1){1'b0}}};
            CSET_ZERO: v = '0;
            CSET_RAND: v = $urandom;
            default:   v = RST_COEF[i];
          endcase
          cfg_write(REG_IDX_W'(i), v);
        end
        cfg_we <= 1'b0;
      end

      for (n = 0; n < ITEMS_PER_PH; n++) begin
        r = $urandom;
        // rails, low-level signal that keeps the filter linear, full-scale noise
        case (r[3:0])
          4'd0:             s = S_MAX;
          4'd1:             s = S_MIN;
          4'd2, 4'd3, 4'd4: s = SB'($signed(r[12:4]));
          default:          s = SB'($urandom);
        endcase
        push_sample(s, ($urandom_range(7) == 0), 1'b0, '0);
        // now and then let the core run dry before the next sample
        if ($urandom_range(63) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (4 * LAT) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bqc_pkg.sv
hw/rtl/bqc_coef_regs.sv
hw/rtl/bqc_mul_round.sv
hw/rtl/biquad_cascade_iir_filter_core.sv
bench/tb.sv
